FILE: design/trr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trr_pkg;

   // default build of the window datapath
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF   = 8;

   // fixed by the 32 bit signed result: root keeps 31 bits
   localparam int OUT_BITS   = 32;
   localparam int ROOT_BITS  = OUT_BITS - 1;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int NBR_CELLS  = 8;

   // register file
   localparam int IN_NODATA_BITS = 16;
   localparam int CSR_IDX_BITS   = 1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_INPUT_NODATA  = 1'b0,
      CSR_OUTPUT_NODATA = 1'b1
   } csr_index_type;

   localparam logic [IN_NODATA_BITS-1:0] IN_NODATA_RST  = 16'h8000;
   localparam logic [OUT_BITS-1:0]       OUT_NODATA_RST = 32'hFFFF_FFFF;

   // what moves from one root cell to the next
   typedef struct packed {
      logic                 valid;
      logic                 missing;
      logic [RAD_BITS-1:0]  rad;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
   } cell_state_type;

endpackage

`default_nettype wire

FILE: design/trr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module trr_front #(
   parameter int SAMPLE_BITS = trr_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = trr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [SAMPLE_BITS-1:0]  nodata,
   input  wire logic [SAMPLE_BITS-1:0]  centre,
   input  wire logic [SAMPLE_BITS-1:0]  nbr[trr_pkg::NBR_CELLS],
   output trr_pkg::cell_state_type      cell_out
);
   import trr_pkg::*;

   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int SQ_W   = 2 * SAMPLE_BITS;
   localparam int PAIR_W = SQ_W + 1;
   localparam int SUM_W  = SQ_W + 3;
   localparam int SHIFT  = 2 * FRAC_BITS;
   localparam int RAD_W  = SUM_W + SHIFT;
   localparam int RADX_W = (RAD_W > RAD_BITS) ? RAD_W : RAD_BITS;

   // stage 1: absolute differences, skipped neighbours forced to zero
   logic [SAMPLE_BITS-1:0] absd_ff[NBR_CELLS];
   logic [SAMPLE_BITS-1:0] absd_in[NBR_CELLS];
   logic                   v1_ff, miss1_ff;

   always_comb begin
      logic signed [DIFF_W-1:0] d;
      for (int j = 0; j < NBR_CELLS; j++) begin
         d = $signed({nbr[j][SAMPLE_BITS-1], nbr[j]}) - $signed({centre[SAMPLE_BITS-1], centre});
         if (nbr[j] == nodata) begin
            absd_in[j] = '0;
         end else if (d[DIFF_W-1]) begin
            absd_in[j] = SAMPLE_BITS'(-d);
         end else begin
            absd_in[j] = d[SAMPLE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      miss1_ff <= (centre == nodata);
      absd_ff  <= absd_in;
   end

   // stage 2: squares
   logic [SQ_W-1:0] sq_ff[NBR_CELLS];
   logic            v2_ff, miss2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      miss2_ff <= miss1_ff;
      for (int j = 0; j < NBR_CELLS; j++) begin
         sq_ff[j] <= SQ_W'(absd_ff[j]) * SQ_W'(absd_ff[j]);
      end
   end

   // stage 3: pairwise sums
   logic [PAIR_W-1:0] pair_ff[NBR_CELLS/2];
   logic              v3_ff, miss3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      miss3_ff <= miss2_ff;
      for (int j = 0; j < NBR_CELLS / 2; j++) begin
         pair_ff[j] <= PAIR_W'(sq_ff[2*j]) + PAIR_W'(sq_ff[2*j+1]);
      end
   end

   // stage 4: final sum, scale to the radicand, clamp when it overflows
   logic [SUM_W-1:0]  sum;
   logic [RADX_W-1:0] rad_wide;
   cell_state_type    cell_in, cell_ff;

   always_comb begin
      sum = (SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]))
          + (SUM_W'(pair_ff[2]) + SUM_W'(pair_ff[3]));
      rad_wide = RADX_W'(sum) << SHIFT;
      cell_in.valid   = v3_ff;
      cell_in.missing = miss3_ff;
      cell_in.rem     = '0;
      cell_in.root    = '0;
      if ((rad_wide >> RAD_BITS) != '0) begin
         cell_in.rad = '1;
      end else begin
         cell_in.rad = rad_wide[RAD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.missing <= cell_in.missing;
      cell_ff.rad     <= cell_in.rad;
      cell_ff.rem     <= cell_in.rem;
      cell_ff.root    <= cell_in.root;
   end

   assign cell_out = cell_ff;

endmodule

`default_nettype wire

FILE: design/trr_root_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module trr_root_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  trr_pkg::cell_state_type cell_prev,
   output trr_pkg::cell_state_type cell_next
);
   import trr_pkg::*;

   localparam int WORK_W = REM_BITS + 2;

   // one restoring square root step: bring down two radicand bits
   logic [WORK_W-1:0] rem_shift;
   logic [WORK_W-1:0] trial;
   cell_state_type    cell_in, cell_ff;

   always_comb begin
      rem_shift = {cell_prev.rem, cell_prev.rad[RAD_BITS-1 -: 2]};
      trial     = WORK_W'({cell_prev.root, 2'b01});
      cell_in.valid   = cell_prev.valid;
      cell_in.missing = cell_prev.missing;
      cell_in.rad     = {cell_prev.rad[RAD_BITS-3:0], 2'b00};
      if (rem_shift >= trial) begin
         cell_in.rem  = REM_BITS'(rem_shift - trial);
         cell_in.root = {cell_prev.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         cell_in.rem  = rem_shift[REM_BITS-1:0];
         cell_in.root = {cell_prev.root[ROOT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.missing <= cell_in.missing;
      cell_ff.rad     <= cell_in.rad;
      cell_ff.rem     <= cell_in.rem;
      cell_ff.root    <= cell_in.root;
   end

   assign cell_next = cell_ff;

endmodule

`default_nettype wire

FILE: design/terrain_ruggedness_3x3.sv
`timescale 1ns / 1ps
`default_nettype none

// terrain ruggedness over one 3x3 elevation window per transaction
//
// request: drive the nine samples on req_cell_* and raise start; the
// transaction is taken at the edge where start is high and busy is low.
// busy stays low, so a new window can be taken on every clock.
// response: rsp_valid is high for one cycle with rsp_ruggedness and
// rsp_centre_missing; the receiver cannot stall, results are never held.
// path: a result passes four front stages (differences, squares, pair sums,
// final sum), then one root cell per result bit, 31 cells, to the ports.
// throughput: one window per cycle, every stage and cell is pipelined.
// csr: write channel (csr_valid/csr_ready, csr_index, csr_data), always
// ready; index 0 is the input no-data sample, index 1 the output no-data
// value. write it only while no transaction is in flight.
// reset: synchronous, clears the pipeline valids and loads input no-data
// 0x8000 and output no-data 0xffffffff.
module terrain_ruggedness_3x3 #(
   parameter int SAMPLE_BITS = trr_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = trr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic [SAMPLE_BITS-1:0]                  req_cell_nw,
   input  wire logic [SAMPLE_BITS-1:0]                  req_cell_n,
   input  wire logic [SAMPLE_BITS-1:0]                  req_cell_ne,
   input  wire logic [SAMPLE_BITS-1:0]                  req_cell_w,
   input  wire logic [SAMPLE_BITS-1:0]                  req_cell_centre,
   input  wire logic [SAMPLE_BITS-1:0]                  req_cell_e,
   input  wire logic [SAMPLE_BITS-1:0]                  req_cell_sw,
   input  wire logic [SAMPLE_BITS-1:0]                  req_cell_s,
   input  wire logic [SAMPLE_BITS-1:0]                  req_cell_se,
   output logic                                         rsp_valid,
   output logic [trr_pkg::OUT_BITS-1:0]                 rsp_ruggedness,
   output logic                                         rsp_centre_missing,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [trr_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  wire logic [trr_pkg::OUT_BITS-1:0]            csr_data
);
   import trr_pkg::*;

   localparam int NODATA_X_W = (SAMPLE_BITS > IN_NODATA_BITS) ? SAMPLE_BITS : IN_NODATA_BITS;

   // configuration registers
   logic [IN_NODATA_BITS-1:0] in_nodata_ff;
   logic [OUT_BITS-1:0]       out_nodata_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_nodata_ff  <= IN_NODATA_RST;
         out_nodata_ff <= OUT_NODATA_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_INPUT_NODATA:  in_nodata_ff  <= csr_data[IN_NODATA_BITS-1:0];
            CSR_OUTPUT_NODATA: out_nodata_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // no-data sample at the window width
   logic [NODATA_X_W-1:0]  nodata_x;
   logic [SAMPLE_BITS-1:0] nodata;
   assign nodata_x = NODATA_X_W'(in_nodata_ff);
   assign nodata   = nodata_x[SAMPLE_BITS-1:0];

   // request side, always ready
   logic                   accept;
   logic [SAMPLE_BITS-1:0] nbr[NBR_CELLS];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign nbr[0] = req_cell_nw;
   assign nbr[1] = req_cell_n;
   assign nbr[2] = req_cell_ne;
   assign nbr[3] = req_cell_w;
   assign nbr[4] = req_cell_e;
   assign nbr[5] = req_cell_sw;
   assign nbr[6] = req_cell_s;
   assign nbr[7] = req_cell_se;

   // squared difference sum and radicand
   cell_state_type chain[ROOT_BITS+1];

   trr_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .nodata   (nodata),
      .centre   (req_cell_centre),
      .nbr      (nbr),
      .cell_out (chain[0])
   );

   // row of root cells, one result bit each
   for (genvar g = 0; g < ROOT_BITS; g++) begin : g_cell
      trr_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_prev (chain[g]),
         .cell_next (chain[g+1])
      );
   end

   // response
   assign rsp_valid          = chain[ROOT_BITS].valid;
   assign rsp_centre_missing = chain[ROOT_BITS].missing;
   assign rsp_ruggedness     = chain[ROOT_BITS].missing ? out_nodata_ff
                                                        : {1'b0, chain[ROOT_BITS].root};

endmodule

`default_nettype wire

FILE: tb/terrain_ruggedness_3x3_tb.sv
`timescale 1ns / 1ps

module terrain_ruggedness_3x3_tb;
   import trr_pkg::*;

   localparam int SAMPLE_BITS     = SAMPLE_BITS_DEF;
   localparam int FRAC_BITS       = FRAC_BITS_DEF;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int SETTLE_CYCLES   = 40;
   localparam int CYCLE_LIMIT     = 100000;

   typedef logic signed [SAMPLE_BITS-1:0] elevation_t;

   typedef struct packed {
      elevation_t nw, n, ne, w, centre, e, sw, s, se;
   } window_t;

   typedef struct packed {
      logic [OUT_BITS-1:0] ruggedness;
      logic                centre_missing;
   } ruggedness_result_t;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   elevation_t              req_cell_nw, req_cell_n, req_cell_ne;
   elevation_t              req_cell_w, req_cell_centre, req_cell_e;
   elevation_t              req_cell_sw, req_cell_s, req_cell_se;
   logic                    rsp_valid;
   logic [OUT_BITS-1:0]     rsp_ruggedness;
   logic                    rsp_centre_missing;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [OUT_BITS-1:0]     csr_data;

   // register copies for the prediction
   elevation_t              model_in_nodata;
   logic [OUT_BITS-1:0]     model_out_nodata;

   ruggedness_result_t      pending_results [$];
   ruggedness_result_t      oldest;
   int                      mismatch_count;
   int                      cycle_count;

   terrain_ruggedness_3x3 uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cell_nw        (req_cell_nw),
      .req_cell_n         (req_cell_n),
      .req_cell_ne        (req_cell_ne),
      .req_cell_w         (req_cell_w),
      .req_cell_centre    (req_cell_centre),
      .req_cell_e         (req_cell_e),
      .req_cell_sw        (req_cell_sw),
      .req_cell_s         (req_cell_s),
      .req_cell_se        (req_cell_se),
      .rsp_valid          (rsp_valid),
      .rsp_ruggedness     (rsp_ruggedness),
      .rsp_centre_missing (rsp_centre_missing),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ruggedness of one window: floor(sqrt(sum of squared differences) * 2^FRAC_BITS)
   function automatic ruggedness_result_t predict_ruggedness(input window_t win);
      elevation_t         nbr [NBR_CELLS];
      longint             diff;
      longint unsigned    sum_sq;
      longint unsigned    scaled;
      longint unsigned    root;
      longint unsigned    trial;
      ruggedness_result_t res;
      int                 i;
      int                 b;
      nbr = '{win.nw, win.n, win.ne, win.w, win.e, win.sw, win.s, win.se};
      res.centre_missing = 1'b0;
      if (win.centre == model_in_nodata) begin
         res.ruggedness     = model_out_nodata;
         res.centre_missing = 1'b1;
         return res;
      end
      sum_sq = 0;
      for (i = 0; i < NBR_CELLS; i++) begin
         if (nbr[i] != model_in_nodata) begin
            diff   = longint'(nbr[i]) - longint'(win.centre);
            sum_sq += longint'(diff * diff);
         end
      end
      // bitwise integer root of the scaled sum, 31 result bits
      scaled = sum_sq << (2 * FRAC_BITS);
      root   = 0;
      for (b = 30; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= scaled)
            root = trial;
      end
      res.ruggedness = root[OUT_BITS-1:0];
      return res;
   endfunction

   // compare each result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: ruggedness %0d centre_missing %0b",
                     $time, $signed(rsp_ruggedness), rsp_centre_missing);
            mismatch_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_ruggedness !== oldest.ruggedness) begin
               $display("%0t ruggedness mismatch: expected %0d actual %0d", $time,
                        $signed(oldest.ruggedness), $signed(rsp_ruggedness));
               mismatch_count++;
            end
            if (rsp_centre_missing !== oldest.centre_missing) begin
               $display("%0t centre_missing mismatch: expected %0b actual %0b", $time,
                        oldest.centre_missing, rsp_centre_missing);
               mismatch_count++;
            end
         end
      end
   end

   // one window transaction, prediction queued at the accepting edge
   task automatic issue_window(input window_t win);
      @(negedge clock);
      start           <= 1'b1;
      req_cell_nw     <= win.nw;
      req_cell_n      <= win.n;
      req_cell_ne     <= win.ne;
      req_cell_w      <= win.w;
      req_cell_centre <= win.centre;
      req_cell_e      <= win.e;
      req_cell_sw     <= win.sw;
      req_cell_s      <= win.s;
      req_cell_se     <= win.se;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_ruggedness(win));
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_for_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [OUT_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_INPUT_NODATA:  model_in_nodata  = data[IN_NODATA_BITS-1:0];
         CSR_OUTPUT_NODATA: model_out_nodata = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic window_t flat_window(input elevation_t centre_val, input elevation_t nbr_val);
      window_t win;
      win        = {9{nbr_val}};
      win.centre = centre_val;
      return win;
   endfunction

   // full range, smooth around a base, or near the rails; sometimes no-data
   function automatic elevation_t random_elevation(input elevation_t base, input int style);
      elevation_t v;
      case (style)
         0: v = elevation_t'($urandom);
         1: v = base + elevation_t'($urandom_range(0, 256)) - elevation_t'(128);
         default: begin
            case ($urandom_range(0, 3))
               0: v = 16'sh7FFF;
               1: v = 16'sh8000;
               2: v = 16'sh8001;
               default: v = base;
            endcase
         end
      endcase
      if ($urandom_range(0, 9) == 0)
         v = model_in_nodata;
      return v;
   endfunction

   function automatic window_t random_window();
      window_t    win;
      elevation_t base;
      int         pick;
      int         style;
      base  = elevation_t'($urandom);
      pick  = $urandom_range(0, 5);
      style = (pick < 2) ? 0 : (pick < 5) ? 1 : 2;
      win.nw     = random_elevation(base, style);
      win.n      = random_elevation(base, style);
      win.ne     = random_elevation(base, style);
      win.w      = random_elevation(base, style);
      win.centre = random_elevation(base, style);
      win.e      = random_elevation(base, style);
      win.sw     = random_elevation(base, style);
      win.s      = random_elevation(base, style);
      win.se     = random_elevation(base, style);
      return win;
   endfunction

   // registers at their reset values
   task automatic test_default_registers();
      window_t win;
      issue_window(flat_window(16'sh8000, 16'sd100));
      issue_window(flat_window(16'sd5, 16'sh8000));
      win   = flat_window(16'sd0, 16'sh8000);
      win.e = 16'sh8001;
      issue_window(win);
   endtask

   // largest differences, flat and small windows, alternating bit patterns
   task automatic test_extreme_windows();
      window_t win;
      issue_window(flat_window(16'sh7FFF, 16'sh8001));
      issue_window(flat_window(16'sh8001, 16'sh7FFF));
      issue_window(flat_window(16'sd0, 16'sd0));
      issue_window(flat_window(16'sd1, 16'sd0));
      issue_window(flat_window(16'sh5555, 16'shAAAA));
      issue_window(flat_window(16'shAAAA, 16'sh5555));
      win = '{nw: 16'sd1, n: 16'sd2, ne: 16'sd3, w: 16'sd4, centre: 16'sd0,
              e: -16'sd5, sw: -16'sd6, s: -16'sd7, se: 16'sh7FFF};
      issue_window(win);
   endtask

   // no-data registers at their extremes, upper write bits ignored
   task automatic test_nodata_registers();
      window_t win;
      wait_for_results();
      write_register(CSR_INPUT_NODATA, 32'h0000_7FFF);
      write_register(CSR_OUTPUT_NODATA, 32'h7FFF_FFFF);
      issue_window(flat_window(16'sh7FFF, 16'sd0));
      issue_window(flat_window(16'sh8000, 16'sh8000));
      issue_window(flat_window(16'sh8000, 16'sh7FFF));
      win    = flat_window(16'sh8000, 16'sh7FFE);
      win.sw = 16'sh7FFF;
      issue_window(win);
      wait_for_results();
      write_register(CSR_INPUT_NODATA, 32'hABCD_0000);
      write_register(CSR_OUTPUT_NODATA, 32'h8000_0000);
      issue_window(flat_window(16'sd0, 16'sd9));
      win    = flat_window(16'sd3, 16'sd0);
      win.nw = -16'sd3;
      issue_window(win);
      wait_for_results();
      write_register(CSR_OUTPUT_NODATA, 32'h0000_0000);
      issue_window(flat_window(16'sd0, -16'sd1));
   endtask

   // random windows over several register settings, sender gaps in bursts
   task automatic test_random_windows();
      int                  phase;
      int                  k;
      logic                quiet;
      logic [OUT_BITS-1:0] data;
      quiet = 1'b0;
      for (phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         data = $urandom;
         case (phase)
            0: data[15:0] = 16'h8000;
            1: data[15:0] = 16'h7FFF;
            2: data[15:0] = 16'h0000;
            3: data[15:0] = 16'hFFFF;
            default: ;
         endcase
         write_register(CSR_INPUT_NODATA, data);
         case (phase)
            0: data = 32'h8000_0000;
            1: data = 32'h7FFF_FFFF;
            2: data = 32'h0000_0000;
            default: data = $urandom;
         endcase
         write_register(CSR_OUTPUT_NODATA, data);
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (k % 40 == 0)
               quiet = ($urandom_range(0, 2) == 0);
            if (phase != PHASES - 1 && !quiet && $urandom_range(0, 3) == 0)
               pause_sender($urandom_range(1, 8));
            issue_window(random_window());
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_cell_nw      = '0;
      req_cell_n       = '0;
      req_cell_ne      = '0;
      req_cell_w       = '0;
      req_cell_centre  = '0;
      req_cell_e       = '0;
      req_cell_sw      = '0;
      req_cell_s       = '0;
      req_cell_se      = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      model_in_nodata  = IN_NODATA_RST;
      model_out_nodata = OUT_NODATA_RST;
      mismatch_count   = 0;
      cycle_count      = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_registers();
      test_extreme_windows();
      test_nodata_registers();
      test_random_windows();

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: terrain_ruggedness_3x3.f
design/trr_pkg.sv
design/trr_front.sv
design/trr_root_cell.sv
design/terrain_ruggedness_3x3.sv
tb/terrain_ruggedness_3x3_tb.sv
